### rtl/twtrd_pkg.sv
// Shared constants, payload types and control codes for the trend regime detector.
`default_nettype none

package twtrd_pkg;

    // Window geometry
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int TIME_W  = 32;
    localparam int PRICE_W = 32;
    localparam int CHG_W   = 16;
    localparam int HRS_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Running totals
    localparam int PTOT_W = PRICE_W + IDX_W;
    localparam int CTOT_W = CHG_W + IDX_W;

    // Arithmetic constants
    localparam int SEC_PER_HOUR = 3600;
    localparam int MIN_ENTRIES  = 3;
    localparam int PCT_Q8       = 25600;
    localparam int PCT_W        = 15;
    localparam int FAC_W        = 17;
    localparam int AGE_W        = HRS_W + 1 + 12;
    localparam int CN_W         = CHG_W + CNT_W + 1;

    // Momentum compare widths
    localparam int MPROD_W = PRICE_W + IDX_W;
    localparam int LHS_W   = MPROD_W + PCT_W;
    localparam int RHS_W   = PTOT_W + FAC_W;
    localparam int PROD_W  = ((LHS_W > RHS_W) ? LHS_W : RHS_W) + 1;
    localparam int LO_W    = PTOT_W / 2;
    localparam int HI_W    = PTOT_W - LO_W;

    typedef struct packed {
        logic [TIME_W-1:0]        time_sec;
        logic [PRICE_W-1:0]       price;
        logic signed [CHG_W-1:0]  change_pct;
    } t_in;

    typedef struct packed {
        logic             risk_on;
        logic             regime_changed;
        logic [CNT_W-1:0] point_count;
        logic             overflow;
    } t_out;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANGE_THR   = 2'd0,
        CFG_MOMENTUM_THR = 2'd1,
        CFG_WINDOW_HOURS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_READ,
        ST_EVICT,
        ST_MUL1,
        ST_MUL2,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic insert;
        logic rd_ahead;
        logic evict_step;
        logic mul1;
        logic mul2;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic evict;
    } t_stat;

endpackage

`default_nettype wire

### rtl/twtrd_dp.sv
// Datapath: ring memories, running totals, eviction test and trend compares.
`default_nettype none

module twtrd_dp
    import twtrd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire t_in                  i_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_out                      o_out
);

    // Ring storage
    logic [TIME_W-1:0]       r_mem_time  [MAX_POINTS];
    logic [PRICE_W-1:0]      r_mem_price [MAX_POINTS];
    logic signed [CHG_W-1:0] r_mem_chg   [MAX_POINTS];
    logic [TIME_W-1:0]       r_rd_time;
    logic [PRICE_W-1:0]      r_rd_price;
    logic signed [CHG_W-1:0] r_rd_chg;

    // Window state
    logic [IDX_W-1:0]         r_oldest;
    logic [CNT_W-1:0]         r_count;
    logic [PTOT_W-1:0]        r_ptot;
    logic signed [CTOT_W-1:0] r_ctot;
    logic                     r_regime;

    // Configuration
    logic signed [CHG_W-1:0]  r_chg_thr;
    logic signed [CHG_W-1:0]  r_mom_thr;
    logic [HRS_W-1:0]         r_win_hrs;

    // Current sample
    logic [TIME_W-1:0]        r_now;
    logic [PRICE_W-1:0]       r_price;
    logic signed [CHG_W-1:0]  r_chg;
    logic                     r_overflow;

    // Compare pipeline
    logic [MPROD_W-1:0]          r_a;
    logic [PTOT_W-1:0]           r_prior;
    logic signed [CN_W-1:0]      r_cthr_n;
    logic signed [FAC_W-1:0]     r_factor;
    logic                        r_few;
    logic [LHS_W-1:0]            r_lhs;
    logic signed [LO_W+FAC_W:0]  r_plo;
    logic signed [HI_W+FAC_W:0]  r_phi;
    logic                        r_chg_ok;
    t_out                        r_out;

    logic [IDX_W-1:0]        oldest_inc;
    logic [CNT_W:0]          wr_sum;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        rd_addr;
    logic                    full;
    logic [AGE_W-1:0]        age_limit;
    logic [TIME_W-1:0]       age;
    logic                    evict;
    logic [IDX_W-1:0]        m_prior;
    logic signed [PROD_W-1:0] rhs;
    logic signed [PROD_W-1:0] lhs;
    logic                    mom_ok;
    logic                    risk;

    always_comb begin
        oldest_inc = (r_oldest == IDX_W'(MAX_POINTS - 1)) ? '0 : r_oldest + 1'b1;
        wr_sum     = (CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_count);
        wr_addr    = (wr_sum >= (CNT_W+1)'(MAX_POINTS))
                   ? IDX_W'(wr_sum - (CNT_W+1)'(MAX_POINTS)) : IDX_W'(wr_sum);
        rd_addr    = i_cmd.rd_ahead ? oldest_inc : r_oldest;
        full       = (r_count == CNT_W'(MAX_POINTS));
        // Older than W whole hours means age >= (W+1)*3600
        age_limit  = (AGE_W'(r_win_hrs) + 1'b1) * AGE_W'(SEC_PER_HOUR);
        age        = r_now - r_rd_time;
        evict      = (r_now >= r_rd_time) && (age >= TIME_W'(age_limit));
        m_prior    = IDX_W'(r_count - 1'b1);
        rhs        = (PROD_W'(r_phi) <<< LO_W) + PROD_W'(r_plo);
        lhs        = $signed(PROD_W'(r_lhs));
        mom_ok     = lhs > rhs;
        risk       = !r_few && r_chg_ok && mom_ok;
    end

    assign o_stat.evict = evict;
    assign o_out        = r_out;

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_mem_time[wr_addr]  <= r_now;
            r_mem_price[wr_addr] <= r_price;
            r_mem_chg[wr_addr]   <= r_chg;
        end
        r_rd_time  <= r_mem_time[rd_addr];
        r_rd_price <= r_mem_price[rd_addr];
        r_rd_chg   <= r_mem_chg[rd_addr];
    end

    // Window state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_count   <= '0;
            r_ptot    <= '0;
            r_ctot    <= '0;
            r_regime  <= 1'b0;
            r_chg_thr <= '0;
            r_mom_thr <= '0;
            r_win_hrs <= HRS_W'(24);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHANGE_THR:   r_chg_thr <= $signed(i_cfg_data);
                    CFG_MOMENTUM_THR: r_mom_thr <= $signed(i_cfg_data);
                    CFG_WINDOW_HOURS: r_win_hrs <= i_cfg_data[HRS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.insert) begin
                if (full) begin
                    // Oldest out, new in: count holds
                    r_ptot   <= r_ptot - PTOT_W'(r_rd_price) + PTOT_W'(r_price);
                    r_ctot   <= r_ctot - CTOT_W'(r_rd_chg) + CTOT_W'(r_chg);
                    r_oldest <= oldest_inc;
                end else begin
                    r_ptot  <= r_ptot + PTOT_W'(r_price);
                    r_ctot  <= r_ctot + CTOT_W'(r_chg);
                    r_count <= r_count + 1'b1;
                end
            end else if (i_cmd.evict_step && evict) begin
                r_ptot   <= r_ptot - PTOT_W'(r_rd_price);
                r_ctot   <= r_ctot - CTOT_W'(r_rd_chg);
                r_oldest <= oldest_inc;
                r_count  <= r_count - 1'b1;
            end
            if (i_cmd.load_out) begin
                r_regime <= risk;
            end
        end
    end

    // Sample latch and compare pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_now   <= i_in.time_sec;
            r_price <= i_in.price;
            r_chg   <= i_in.change_pct;
        end
        if (i_cmd.insert) begin
            r_overflow <= full;
        end
        if (i_cmd.mul1) begin
            r_a      <= MPROD_W'(r_price) * MPROD_W'(m_prior);
            r_prior  <= r_ptot - PTOT_W'(r_price);
            r_cthr_n <= CN_W'(r_chg_thr) * $signed(CN_W'(r_count));
            r_factor <= FAC_W'(r_mom_thr) + FAC_W'(PCT_Q8);
            r_few    <= (r_count < CNT_W'(MIN_ENTRIES));
        end
        if (i_cmd.mul2) begin
            r_lhs    <= LHS_W'(r_a) * LHS_W'(PCT_Q8);
            r_plo    <= $signed({1'b0, r_prior[LO_W-1:0]}) * r_factor;
            r_phi    <= $signed({1'b0, r_prior[PTOT_W-1:LO_W]}) * r_factor;
            r_chg_ok <= CN_W'(r_ctot) > r_cthr_n;
        end
        if (i_cmd.load_out) begin
            r_out.risk_on        <= risk;
            r_out.regime_changed <= risk ^ r_regime;
            r_out.point_count    <= r_count;
            r_out.overflow       <= r_overflow;
        end
    end

endmodule

`default_nettype wire

### rtl/twtrd_ctrl.sv
// Controller: sequences insert, eviction, compares and the output beat.
`default_nettype none

module twtrd_ctrl
    import twtrd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_INSERT;
                end
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_READ;
            end
            ST_READ: begin
                n_state = ST_EVICT;
            end
            ST_EVICT: begin
                // Prefetch next-oldest so a drop can repeat every cycle
                o_cmd.evict_step = 1'b1;
                o_cmd.rd_ahead   = 1'b1;
                if (!i_stat.evict) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/time_window_trend_regime_detector.sv
// Top level of the time-window trend regime detector.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one sample beat:
//   time in seconds, Q16.16 price, Q8.8 percent change. Each sample gives
//   exactly one result beat on the output channel (o_out_valid /
//   i_out_ready / o_out): risk_on, regime_changed, point_count, overflow.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; write only
//   while no sample is in flight. Index 0 change threshold, 1 momentum
//   threshold, 2 window hours.
//   The eviction loop drops one entry a cycle through the single read port
//   of the ring memory; at most 63 entries go per sample, as the newest
//   always stays. The momentum compare runs split multiplies (MUL1, then
//   MUL2) before the final compare. One sample is in work at a time: the
//   next sample is taken in the cycle after the result is loaded.
//   A finished result waits in the output register; a stalled receiver
//   only holds the controller in its last step once a second result is
//   ready. Reset empties the window, clears risk and loads the default
//   thresholds (0, 0) and window (24 hours); the ring memory needs no
//   clearing since only entries inside the window are ever read.
`default_nettype none

module time_window_trend_regime_detector
    import twtrd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in                  i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out                      o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Config writes are always accepted
    assign o_cfg_ready = 1'b1;

    twtrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    twtrd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### rtl/twtrd_chk.sv
// Port-level checker for the trend regime detector, bound to the top level.
`default_nettype none

module twtrd_chk
    import twtrd_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire t_in                  i_in,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire t_out                 o_out,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [CFG_W-1:0]     i_cfg_data
);

    // risk_on of the last delivered beat
    logic r_last_risk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_risk <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_last_risk <= o_out.risk_on;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat dropped or changed while stalled");

    a_regime_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.regime_changed == (o_out.risk_on != r_last_risk)))
        else $error("regime_changed disagrees with previous risk_on");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.point_count >= CNT_W'(1))
                     && (o_out.point_count <= CNT_W'(MAX_POINTS)))
        else $error("point_count out of range");

    a_risk_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.risk_on |-> (o_out.point_count >= CNT_W'(MIN_ENTRIES)))
        else $error("risk_on with too few entries");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second sample taken while one is in work");

endmodule

bind time_window_trend_regime_detector twtrd_chk u_twtrd_chk (.*);

`default_nettype wire

### tb/sv/time_window_trend_regime_detector_test.sv
// Self-checking testbench for the time-window trend regime detector.
`timescale 1ns / 100ps

module time_window_trend_regime_detector_test
    import twtrd_pkg::*;
();

    // Run control
    localparam int CYCLE_LIMIT   = 600000;  // far above the slowest legal run
    localparam int SETTLE_CYCLES = 80;      // room for a result after 63 evictions, with margin
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 67;
    localparam int RING_DEPTH    = 64;
    localparam int HOUR_SEC      = 3600;
    localparam int MIN_FILL      = 3;
    localparam longint PCT_ONE   = 25600;   // 100 % in Q8.8

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    // One line of the directed script: a sample beat or a register write.
    typedef struct {
        t_row_kind   kind;
        t_in         beat;
        t_cfg_idx    reg_idx;
        logic [15:0] reg_data;
        bit          typed;     // expected result given by hand
        t_out        want;
    } t_script_row;

    // DUT connections; every input has a known value from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in                  in_beat   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_beat;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Idle knobs, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    t_out        verdicts_due[$];   // predicted result beats, oldest first
    t_script_row script[$];

    // Shadow of the window: ring, running totals, last regime, registers
    logic [31:0]        win_time [RING_DEPTH];
    logic [31:0]        win_price[RING_DEPTH];
    logic signed [15:0] win_chg  [RING_DEPTH];
    int unsigned        head       = 0;
    int unsigned        fill       = 0;
    longint             price_sum  = 0;
    longint             chg_sum    = 0;
    bit                 risk_prev  = 1'b0;
    logic signed [15:0] thr_change = '0;
    logic signed [15:0] thr_mom    = '0;
    logic [7:0]         win_hours  = 8'd24;

    time_window_trend_regime_detector DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------

    // Pop the oldest entry and take it out of both running totals.
    function automatic void retire_oldest();
        price_sum -= win_price[head];
        chg_sum   -= win_chg[head];
        head       = (head + 1) % RING_DEPTH;
        fill--;
    endfunction

    // Insert one sample, evict stale entries, and decide the regime.
    function automatic t_out advance_window(t_in s);
        t_out        r;
        int unsigned slot;
        logic [31:0] age_hrs;
        longint      n, cur, prior;
        bit          chg_ok, mom_ok, risk;
        r = '0;
        // Full ring: the oldest entry makes room before the insert
        if (fill >= RING_DEPTH) begin
            retire_oldest();
            r.overflow = 1'b1;
        end
        slot            = (head + fill) % RING_DEPTH;
        win_time[slot]  = s.time_sec;
        win_price[slot] = s.price;
        win_chg[slot]   = $signed(s.change_pct);
        price_sum      += longint'(s.price);
        chg_sum        += longint'($signed(s.change_pct));
        fill++;
        // Eviction from the oldest end only; an entry stamped in the future
        // counts as zero hours old and stops the scan.
        while (fill > 0) begin
            if (s.time_sec >= win_time[head])
                age_hrs = (s.time_sec - win_time[head]) / 32'(HOUR_SEC);
            else
                age_hrs = '0;
            if (age_hrs > {24'd0, win_hours})
                retire_oldest();
            else
                break;
        end
        risk = 1'b0;
        if (fill >= MIN_FILL) begin
            n      = longint'(fill);
            cur    = longint'(win_price[(head + fill - 1) % RING_DEPTH]);
            prior  = price_sum - cur;
            // mean change > thr  <=>  sum > thr * n
            chg_ok = chg_sum > longint'(thr_change) * n;
            // 100 * (cur / mean_prior - 1) > thr, scaled by (n - 1) * prior;
            // the factor goes negative for thresholds below -100 %
            mom_ok = PCT_ONE * cur * (n - 1) > prior * (longint'(thr_mom) + PCT_ONE);
            risk   = chg_ok && mom_ok;
        end
        r.risk_on        = risk;
        r.regime_changed = (risk != risk_prev);
        r.point_count    = 7'(fill);
        risk_prev        = risk;
        return r;
    endfunction

    function automatic void apply_register(t_cfg_idx idx, logic [15:0] data);
        case (idx)
            CFG_CHANGE_THR:   thr_change = data;
            CFG_MOMENTUM_THR: thr_mom    = data;
            CFG_WINDOW_HOURS: win_hours  = data[7:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Script rows
    // ------------------------------------------------------------------

    function automatic t_script_row sample_row(logic [31:0] t, logic [31:0] p,
                                               logic [15:0] c);
        t_script_row row;
        row.kind            = ROW_SAMPLE;
        row.beat.time_sec   = t;
        row.beat.price      = p;
        row.beat.change_pct = c;
        row.reg_idx         = CFG_CHANGE_THR;
        row.reg_data        = '0;
        row.typed           = 1'b0;
        row.want            = '0;
        return row;
    endfunction

    function automatic t_script_row typed_row(logic [31:0] t, logic [31:0] p,
                                              logic [15:0] c, logic [6:0] cnt);
        t_script_row row;
        row                  = sample_row(t, p, c);
        row.typed            = 1'b1;
        row.want.point_count = cnt;   // risk, change and overflow stay 0
        return row;
    endfunction

    function automatic t_script_row write_row(t_cfg_idx idx, logic [15:0] data);
        t_script_row row;
        row.kind     = ROW_WRITE;
        row.beat     = '0;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.typed    = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    // Append one row at the end of the script.
    function automatic void add_row(t_script_row row);
        script.insert(script.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Drop both valids and wait until every predicted beat has come back.
    // The queue is polled on the falling edge, clear of the result monitor.
    task automatic hold_until_idle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        hold_until_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, data);
    endtask

    // Valid stays high across back-to-back beats; it only drops for a gap,
    // so no edge ever sees two assignments to it.
    task automatic send_sample(t_in s, bit typed, t_out want);
        t_out guess;
        cfg_valid <= 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_beat  <= s;
        do @(posedge clk); while (!in_ready);
        guess = advance_window(s);
        verdicts_due.insert(verdicts_due.size(), typed ? want : guess);
    endtask

    task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge clk) begin : take_result
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("result beat %h arrived with nothing pending", out_beat);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                compare_field("risk_on", 8'(want.risk_on), 8'(out_beat.risk_on));
                compare_field("regime_changed", 8'(want.regime_changed),
                              8'(out_beat.regime_changed));
                compare_field("point_count", 8'(want.point_count),
                              8'(out_beat.point_count));
                compare_field("overflow", 8'(want.overflow), 8'(out_beat.overflow));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[time_window_trend_regime_detector] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] clock_sec;
        logic [31:0] px;
        logic [31:0] step;
        logic [15:0] chg;
        logic [15:0] thr_c, thr_m;
        logic [7:0]  hrs;
        bit          steady;
        int          pick;
        t_in         s;

        // Directed script. Defaults after reset: thresholds 0, 24 h window.
        add_row(typed_row(32'd0,  32'h0001_0000, 16'h0100, 7'd1));
        add_row(typed_row(32'd60, 32'h0001_0000, 16'h0100, 7'd2));
        add_row(sample_row(32'd120, 32'h0002_0000, 16'h0001));
        add_row(sample_row(32'd120, 32'hFFFF_FFFF, 16'h7FFF));
        add_row(sample_row(32'd7200, 32'h0, 16'h8000));
        // clock stepping back: newest stamp older than the last one held
        add_row(sample_row(32'd3600, 32'h0003_0000, 16'h0000));
        // 25 h past the first samples: those age out, the later ones stay
        add_row(sample_row(32'd90120, 32'h0001_0000, 16'h0000));
        // zero window: anything a full hour old goes
        add_row(write_row(CFG_WINDOW_HOURS, 16'd0));
        add_row(sample_row(32'd93719, 32'h0001_0000, 16'h0200));
        add_row(sample_row(32'd93720, 32'h0001_0000, 16'h0200));
        add_row(sample_row(32'd97320, 32'h0001_0000, 16'h0200));
        // earlier prices all zero, then a nonzero price; lowest change bar
        add_row(write_row(CFG_WINDOW_HOURS, 16'd255));
        add_row(write_row(CFG_CHANGE_THR, 16'h8000));
        add_row(write_row(CFG_MOMENTUM_THR, 16'h0000));
        add_row(sample_row(32'd2000000, 32'h0, 16'h0000));
        add_row(sample_row(32'd2000001, 32'h0, 16'h0000));
        add_row(sample_row(32'd2000002, 32'h0005_0000, 16'h8000));
        add_row(sample_row(32'd2000003, 32'h0, 16'h0000));
        // momentum bar below -100 %: negative factor on the prior side
        add_row(write_row(CFG_MOMENTUM_THR, 16'h8000));
        add_row(sample_row(32'd2000004, 32'h1234_5678, 16'h7FFF));
        add_row(sample_row(32'd2000005, 32'h0, 16'h7FFF));
        // highest bars: risk can never come on
        add_row(write_row(CFG_CHANGE_THR, 16'h7FFF));
        add_row(write_row(CFG_MOMENTUM_THR, 16'h7FFF));
        add_row(sample_row(32'd2000006, 32'hFFFF_FFFF, 16'h7FFF));
        add_row(sample_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF));
        add_row(sample_row(32'd0, 32'h0000_0001, 16'hFFFF));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE)
                cfg_write(script[i].reg_idx, script[i].reg_data);
            else
                send_sample(script[i].beat, script[i].typed, script[i].want);
        end

        // Random phases: new registers and a new idle pattern each time.
        clock_sec = 32'd1;
        px        = 32'h0064_0000;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // Steady phases keep every sample inside a wide window so the
            // ring fills up and wraps.
            steady = (phase == 0 || phase == 5);
            case (phase)
                0: begin thr_c = 16'h8000; thr_m = 16'h8000; hrs = 8'd255; end
                1: begin thr_c = 16'h7FFF; thr_m = 16'h7FFF; hrs = 8'd1;   end
                2: begin thr_c = 16'h0000; thr_m = 16'(-25599); hrs = 8'd0; end
                default: begin
                    thr_c = 16'($urandom_range(0, 1023)) - 16'd512;
                    thr_m = 16'($urandom_range(0, 5119)) - 16'd2560;
                    if (steady)
                        hrs = 8'd255;
                    else if ($urandom_range(99) < 30)
                        hrs = 8'($urandom_range(1, 4));
                    else
                        hrs = 8'($urandom_range(5, 255));
                end
            endcase
            cfg_write(CFG_CHANGE_THR, thr_c);
            cfg_write(CFG_MOMENTUM_THR, thr_m);
            cfg_write(CFG_WINDOW_HOURS, {8'd0, hrs});

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase

            for (int k = 0; k < PHASE_BEATS; k++) begin
                // Timestamp: mostly small forward steps, some backward
                // steps, jumps past the window and fresh random times.
                pick = $urandom_range(99);
                if (pick < 6)
                    clock_sec -= 32'($urandom_range(1, 7200));
                else if (!steady && pick < 12)
                    clock_sec += 32'($urandom_range(HOUR_SEC, HOUR_SEC * (hrs + 2)));
                else if (!steady && pick < 15)
                    clock_sec = $urandom;
                else
                    clock_sec += 32'($urandom_range(0, steady ? 900 : 1800));

                // Price: random walk, with zeros and full-range outliers
                pick = $urandom_range(99);
                if (pick < 3) begin
                    px = '0;
                end else if (pick < 10) begin
                    px = $urandom;
                end else begin
                    if (px < 32'd16)
                        px = 32'($urandom_range(32'h0000_8000, 32'h0100_0000));
                    step = px >> $urandom_range(2, 7);
                    if ($urandom_range(1))
                        px += step;
                    else
                        px -= step;
                end

                // Change: mostly near the thresholds, sometimes any value
                if ($urandom_range(99) < 20)
                    chg = 16'($urandom);
                else
                    chg = 16'($urandom_range(0, 2047)) - 16'd1024;

                s.time_sec   = clock_sec;
                s.price      = px;
                s.change_pct = chg;
                send_sample(s, 1'b0, '0);
            end
        end

        // Drain, then give a late or stray beat time to show up.
        hold_until_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("[time_window_trend_regime_detector] OK");
        else
            $display("[time_window_trend_regime_detector] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/twtrd_pkg.sv
rtl/twtrd_dp.sv
rtl/twtrd_ctrl.sv
rtl/time_window_trend_regime_detector.sv
rtl/twtrd_chk.sv
tb/sv/time_window_trend_regime_detector_test.sv
